// ----- hw/rtl/detc_pkg.sv -----
// Shared constants, register codes and configuration type of the turn counter.
package detc_pkg;

    // Single-turn resolution of each encoder (power of two)
    localparam int TICKS_PER_TURN = 65536;
    localparam int TICKS_LOG2     = $clog2(TICKS_PER_TURN);

    // Field widths
    localparam int READING_W = 16;
    localparam int TEETH_W   = 8;
    localparam int COEF_W    = 9;
    localparam int TURN_W    = 9;

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    // Datapath widths: weighted sum, its quotient by the turn size, coefficient product
    localparam int SUM_W  = READING_W + TEETH_W + 2;
    localparam int QUO_W  = SUM_W - TICKS_LOG2;
    localparam int PROD_W = TEETH_W + COEF_W;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NEW_DEVICE_MODE     = 3'd0,
        REG_HAND_SIDE           = 3'd1,
        REG_FIRST_WHEEL_TEETH   = 3'd2,
        REG_SECOND_WHEEL_TEETH  = 3'd3,
        REG_INVERSE_COEFFICIENT = 3'd4
    } cfg_reg_t;

    // Register file contents, handed to the datapath stages
    typedef struct packed {
        logic                      new_device_mode;
        logic                      hand_side;
        logic [TEETH_W-1:0]        first_wheel_teeth;
        logic [TEETH_W-1:0]        second_wheel_teeth;
        logic signed [COEF_W-1:0]  inverse_coefficient;
    } cfg_t;

endpackage

// ----- hw/rtl/dual_encoder_turn_count.sv -----
// Pipeline order from s_ beat to m_ beat: front, quotient remainder, mix, product remainder, back.
// Throughput: one beat per cycle while m_tready is not held low; the two remainder pipelines (two
// quotient bits per stage, 7 and 11 stages) set the depth. Every stage holds a valid bit and takes a new
// beat whenever it is empty, so bubbles close up while the output waits.
// Reset: synchronous, active low; clears all valid bits and loads the register
// defaults. No clearing pass; the block takes beats in the first cycle after reset.
module dual_encoder_turn_count (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [15:0] first_reading, [31:16] second_reading
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [detc_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [8:0] turn_count, [15:9] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [detc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [detc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [detc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import detc_pkg::*;

    cfg_t                     cfg_reg;

    logic                     f_valid;
    logic                     f_ready;
    logic signed [QUO_W-1:0]  f_quo;
    logic                     f_round;

    logic                     r1_valid;
    logic                     r1_ready;
    logic [TEETH_W-1:0]       r1_rem;
    logic                     r1_round;

    logic                     x_valid;
    logic                     x_ready;
    logic signed [PROD_W-1:0] x_prod;

    logic                     r2_valid;
    logic                     r2_ready;
    logic [TEETH_W-1:0]       r2_rem;
    logic                     r2_side;

    logic [TURN_W-1:0]        turn_count;

    // Register file writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.new_device_mode     <= 1'b0;
            cfg_reg.hand_side           <= 1'b0;
            cfg_reg.first_wheel_teeth   <= TEETH_W'(1);
            cfg_reg.second_wheel_teeth  <= TEETH_W'(1);
            cfg_reg.inverse_coefficient <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_NEW_DEVICE_MODE: begin
                    cfg_reg.new_device_mode <= cfg_wr_data[0];
                end
                REG_HAND_SIDE: begin
                    cfg_reg.hand_side <= cfg_wr_data[0];
                end
                REG_FIRST_WHEEL_TEETH: begin
                    cfg_reg.first_wheel_teeth <= cfg_wr_data[TEETH_W-1:0];
                end
                REG_SECOND_WHEEL_TEETH: begin
                    cfg_reg.second_wheel_teeth <= cfg_wr_data[TEETH_W-1:0];
                end
                REG_INVERSE_COEFFICIENT: begin
                    cfg_reg.inverse_coefficient <= $signed(cfg_wr_data[COEF_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Weighted sum and turn quotient
    detc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .first_reading  ($signed(s_tdata[READING_W-1:0])),
        .second_reading ($signed(s_tdata[2*READING_W-1:READING_W])),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .quo            (f_quo),
        .round_up       (f_round)
    );

    // Quotient modulo N2, round bit rides along
    detc_rem #(
        .DW (QUO_W),
        .SW (1)
    ) u_rem_quo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .divisor     (cfg_reg.second_wheel_teeth),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .in_dividend (f_quo),
        .in_side     (f_round),
        .out_valid   (r1_valid),
        .out_ready   (r1_ready),
        .out_rem     (r1_rem),
        .out_side    (r1_round)
    );

    // Rounded estimate times inverse
    detc_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (r1_valid),
        .in_ready  (r1_ready),
        .quo_mod   (r1_rem),
        .round_up  (r1_round),
        .out_valid (x_valid),
        .out_ready (x_ready),
        .prod      (x_prod)
    );

    // Product modulo N2
    detc_rem #(
        .DW (PROD_W),
        .SW (1)
    ) u_rem_prod (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .divisor     (cfg_reg.second_wheel_teeth),
        .in_valid    (x_valid),
        .in_ready    (x_ready),
        .in_dividend (x_prod),
        .in_side     (1'b0),
        .out_valid   (r2_valid),
        .out_ready   (r2_ready),
        .out_rem     (r2_rem),
        .out_side    (r2_side)
    );

    // Mode mapping and output register; the spare side bit is constant zero
    detc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (r2_valid && !r2_side),
        .in_ready   (r2_ready),
        .residue    (r2_rem),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .turn_count (turn_count)
    );

    assign m_tdata = M_TDATA_W'(turn_count);

endmodule

// ----- hw/rtl/detc_front.sv -----
// Front stages: weighted sum of the two readings, split into turn quotient and round bit.
module detc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  detc_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [detc_pkg::READING_W-1:0] first_reading,
    input  logic signed [detc_pkg::READING_W-1:0] second_reading,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [detc_pkg::QUO_W-1:0]     quo,
    output logic                                  round_up
);
    import detc_pkg::*;

    localparam int PRD_W = READING_W + TEETH_W + 1;

    logic                    v0_reg;
    logic                    v1_reg;
    logic signed [PRD_W-1:0] prod1_reg;
    logic signed [PRD_W-1:0] prod2_reg;
    logic signed [PRD_W-1:0] prod1_next;
    logic signed [PRD_W-1:0] prod2_next;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [QUO_W-1:0] quo_reg;
    logic                    round_reg;
    logic                    flip;
    logic                    rdy0;
    logic                    rdy1;

    // A stage takes a beat when it is empty or its content moves on
    assign rdy1     = !v1_reg || out_ready;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // Left side in the newer mode uses the second reading negated
    assign flip = cfg.new_device_mode && cfg.hand_side;

    // Stage 0: tooth-weighted readings
    assign prod1_next = $signed({1'b0, cfg.first_wheel_teeth}) * first_reading;
    assign prod2_next = $signed({1'b0, cfg.second_wheel_teeth}) * second_reading;

    // Stage 1: -N2*p2 - N1*p1, or N2*p2 - N1*p1 when flipped; upper bits are the floored turn quotient
    always_comb begin
        if (flip) begin
            sum_next = SUM_W'(prod2_reg) - SUM_W'(prod1_reg);
        end else begin
            sum_next = -SUM_W'(prod2_reg) - SUM_W'(prod1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                v0_reg <= in_valid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && in_valid) begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
        if (rdy1 && v0_reg) begin
            quo_reg   <= sum_next[SUM_W-1:TICKS_LOG2];
            round_reg <= sum_next[TICKS_LOG2-1];
        end
    end

    assign out_valid = v1_reg;
    assign quo       = quo_reg;
    assign round_up  = round_reg;

endmodule

// ----- hw/rtl/detc_rem.sv -----
// Pipelined floored remainder of a signed value by an 8-bit divisor, two bits per stage.
module detc_rem #(
    parameter int DW = 10,
    parameter int SW = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [detc_pkg::TEETH_W-1:0]      divisor,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DW-1:0]              in_dividend,
    input  logic [SW-1:0]                     in_side,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [detc_pkg::TEETH_W-1:0]      out_rem,
    output logic [SW-1:0]                     out_side
);
    import detc_pkg::*;

    localparam int NST = (DW + 1) / 2;
    localparam int MW  = 2 * NST;
    localparam int NS  = NST + 2;

    // One restoring step: shift in a dividend bit, subtract the divisor if it fits
    function automatic logic [TEETH_W-1:0] rem_step(input logic [TEETH_W-1:0] r,
                                                    input logic b,
                                                    input logic [TEETH_W-1:0] d);
        logic [TEETH_W:0] t;
        logic [TEETH_W:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        return (t >= {1'b0, d}) ? diff[TEETH_W-1:0] : t[TEETH_W-1:0];
    endfunction

    logic               v_reg    [NS];
    logic [MW-1:0]      mag_reg  [NS];
    logic [TEETH_W-1:0] rem_reg  [NS];
    logic               neg_reg  [NS];
    logic [SW-1:0]      side_reg [NS];

    logic               v_next    [NS];
    logic [MW-1:0]      mag_next  [NS];
    logic [TEETH_W-1:0] rem_next  [NS];
    logic               neg_next  [NS];
    logic [SW-1:0]      side_next [NS];

    logic               rdy [NS+1];
    logic [DW-1:0]      mag_abs;

    // Magnitude of the dividend; the most negative value maps to its unsigned twin
    assign mag_abs = in_dividend[DW-1] ? DW'(-in_dividend) : in_dividend;

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_entry
            // Load magnitude, clear partial remainder
            assign v_next[k]    = in_valid;
            assign mag_next[k]  = MW'(mag_abs);
            assign rem_next[k]  = '0;
            assign neg_next[k]  = in_dividend[DW-1];
            assign side_next[k] = in_side;
        end else if (k < NS - 1) begin : g_div
            logic [TEETH_W-1:0] r1;
            // Two dividend bits, most significant first
            assign r1           = rem_step(rem_reg[k-1], mag_reg[k-1][MW-1], divisor);
            assign rem_next[k]  = rem_step(r1, mag_reg[k-1][MW-2], divisor);
            assign mag_next[k]  = mag_reg[k-1] << 2;
            assign v_next[k]    = v_reg[k-1];
            assign neg_next[k]  = neg_reg[k-1];
            assign side_next[k] = side_reg[k-1];
        end else begin : g_fix
            // Negative dividend with nonzero remainder: fold into [0, divisor)
            assign rem_next[k]  = (neg_reg[k-1] && (rem_reg[k-1] != '0))
                                  ? divisor - rem_reg[k-1] : rem_reg[k-1];
            assign mag_next[k]  = mag_reg[k-1];
            assign v_next[k]    = v_reg[k-1];
            assign neg_next[k]  = neg_reg[k-1];
            assign side_next[k] = side_reg[k-1];
        end

        // Take a beat when empty or when the content moves on
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && v_next[k]) begin
                mag_reg[k]  <= mag_next[k];
                rem_reg[k]  <= rem_next[k];
                neg_reg[k]  <= neg_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_rem   = rem_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- hw/rtl/detc_mix.sv -----
// Rounded turn estimate times the inverse coefficient.
module detc_mix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  detc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [detc_pkg::TEETH_W-1:0]        quo_mod,
    input  logic                                round_up,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [detc_pkg::PROD_W-1:0]  prod
);
    import detc_pkg::*;

    logic                      v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [TEETH_W:0]          x_sum;
    logic [TEETH_W-1:0]        x;
    logic signed [PROD_W:0]    prod_full;
    logic                      rdy;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    // Round to nearest turn, then weight by the inverse; the estimate stays below 256
    assign x_sum     = {1'b0, quo_mod} + (TEETH_W+1)'(round_up);
    assign x         = x_sum[TEETH_W-1:0];
    assign prod_full = $signed({1'b0, x}) * cfg.inverse_coefficient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_valid) begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
    end

    assign out_valid = v_reg;
    assign prod      = prod_reg;

endmodule

// ----- hw/rtl/detc_back.sv -----
// Output stage: map the residue to a signed turn count per mode and hold the result beat.
module detc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  detc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [detc_pkg::TEETH_W-1:0]        residue,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [detc_pkg::TURN_W-1:0]         turn_count
);
    import detc_pkg::*;

    logic               v_reg;
    logic [TURN_W-1:0]  turn_reg;
    logic [TURN_W-1:0]  turn_next;
    logic [TEETH_W-1:0] half;
    logic [TEETH_W:0]   shifted;
    logic [TEETH_W:0]   wrapped;
    logic               rdy;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    // Symmetric wrap: ((a + N2/2) mod N2) - N2/2, one subtract suffices
    assign half    = cfg.second_wheel_teeth >> 1;
    assign shifted = {1'b0, residue} + {1'b0, half};
    assign wrapped = (shifted >= {1'b0, cfg.second_wheel_teeth})
                     ? shifted - {1'b0, cfg.second_wheel_teeth} : shifted;

    always_comb begin
        priority if (cfg.second_wheel_teeth == '0) begin
            turn_next = '0;
        end else if (!cfg.new_device_mode) begin
            turn_next = wrapped - {1'b0, half};
        end else if (cfg.hand_side) begin
            turn_next = {1'b0, residue};
        end else if (residue == '0) begin
            turn_next = '0;
        end else begin
            turn_next = {1'b0, residue} - {1'b0, cfg.second_wheel_teeth};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_valid) begin
            turn_reg <= turn_next;
        end
    end

    assign out_valid  = v_reg;
    assign turn_count = turn_reg;

endmodule

// ----- hw/rtl/detc_checker.sv -----
// Port-level checker for the turn counter, bound to the top level.
module detc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [detc_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [detc_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               cfg_wr_en,
    input logic [detc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input logic [detc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import detc_pkg::*;

    logic               mode_reg;
    logic               hand_reg;
    logic [TEETH_W-1:0] n2_reg;
    logic signed [TURN_W:0] tc;
    logic signed [TURN_W:0] n2s;
    logic signed [TURN_W:0] hs;
    logic               in_beat;

    // Track the mode, hand side and modulus as written on the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            hand_reg <= 1'b0;
            n2_reg   <= TEETH_W'(1);
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_NEW_DEVICE_MODE) begin
                mode_reg <= cfg_wr_data[0];
            end
            if (cfg_addr == REG_HAND_SIDE) begin
                hand_reg <= cfg_wr_data[0];
            end
            if (cfg_addr == REG_SECOND_WHEEL_TEETH) begin
                n2_reg <= cfg_wr_data[TEETH_W-1:0];
            end
        end
    end

    assign tc      = (TURN_W+1)'($signed(m_tdata[TURN_W-1:0]));
    assign n2s     = $signed({2'b00, n2_reg});
    assign hs      = $signed({2'b00, n2_reg >> 1});
    assign in_beat = s_tvalid && s_tready && (s_tdata != '0 || s_tdata == '0);

    // Output is idle right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Newer mode, right side: count lies in (-N2, 0]
    a_right_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_reg && !hand_reg && n2_reg != '0
        |-> tc <= 0 && tc > -n2s)
        else $error("right-side turn count out of range");

    // Newer mode, left side: count lies in [0, N2)
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_reg && hand_reg && n2_reg != '0
        |-> tc >= 0 && tc < n2s)
        else $error("left-side turn count out of range");

    // Legacy mode: count wraps round zero and the padding bits stay zero
    a_legacy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !mode_reg && n2_reg != '0 && (in_beat || !in_beat)
        |-> tc >= -hs && tc < n2s - hs && m_tdata[M_TDATA_W-1:TURN_W] == '0)
        else $error("legacy turn count out of range");

endmodule

bind dual_encoder_turn_count detc_checker u_detc_checker (.*);

// ----- tb/turn_count_checker.sv -----
// Turn count checker: tracks register writes, predicts each turn count and compares beats.
module turn_count_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // s_tdata: [15:0] first_reading, [31:16] second_reading
    input  logic [detc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [8:0] turn_count, [15:9] zero
    input  logic [detc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [detc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [detc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 turns_checked
);
    import detc_pkg::*;

    cfg_t                      shadow_cfg;
    logic [TURN_W-1:0]         expected_turns[$];
    int                        bad_count;
    int                        beat_count;

    // Floored remainder, always in [0, d) for positive d
    function automatic longint floor_mod(longint v, longint d);
        longint r;
        r = v % d;
        if (r < 0) begin
            r += d;
        end
        return r;
    endfunction

    // Vernier turn count for one reading pair under the given register set
    function automatic logic [TURN_W-1:0] predict_turns(logic signed [READING_W-1:0] p1,
                                                       logic signed [READING_W-1:0] p2,
                                                       cfg_t c);
        longint first_pos;
        longint second_pos;
        longint n1;
        longint n2;
        longint coef;
        longint x;
        longint a;
        longint turns;
        first_pos  = p1;
        second_pos = p2;
        n1         = c.first_wheel_teeth;
        n2         = c.second_wheel_teeth;
        coef       = longint'($signed(c.inverse_coefficient));
        // A zero modulus has no defined count
        if (n2 == 0) begin
            return '0;
        end
        // In the new mode a left-side mount mirrors the second encoder
        if (c.new_device_mode && c.hand_side) begin
            second_pos = -second_pos;
        end
        x = (floor_mod(-n2 * second_pos - n1 * first_pos, longint'(TICKS_PER_TURN) * n2)
             + TICKS_PER_TURN / 2) / TICKS_PER_TURN;
        a = floor_mod(x * coef, n2);
        if (c.new_device_mode) begin
            if (c.hand_side) begin
                turns = a;
            end else begin
                turns = (a == 0) ? 0 : a - n2;
            end
        end else begin
            turns = floor_mod(a + n2 / 2, n2) - n2 / 2;
        end
        return turns[TURN_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [M_TDATA_W-1:0] want,
                                   logic [M_TDATA_W-1:0] got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("mismatch at result %0d: %s, expected %h, got %h",
                     beat_count, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        logic [TURN_W-1:0] want;
        if (!aresetn) begin
            shadow_cfg.new_device_mode     = 1'b0;
            shadow_cfg.hand_side           = 1'b0;
            shadow_cfg.first_wheel_teeth   = 8'd1;
            shadow_cfg.second_wheel_teeth  = 8'd1;
            shadow_cfg.inverse_coefficient = '0;
            expected_turns.delete();
        end else begin
            // Compare the outgoing beat first so a same-edge input is not matched to it
            if (m_tvalid && m_tready) begin
                if (expected_turns.size() == 0) begin
                    report_mismatch("result with nothing expected", 'x, m_tdata);
                end else begin
                    want = expected_turns.pop_front();
                    if (m_tdata[TURN_W-1:0] !== want) begin
                        report_mismatch("turn_count", {{(M_TDATA_W-TURN_W){1'b0}}, want},
                                        m_tdata);
                    end else if (m_tdata[M_TDATA_W-1:TURN_W] !== '0) begin
                        report_mismatch("padding bits", {{(M_TDATA_W-TURN_W){1'b0}}, want},
                                        m_tdata);
                    end
                end
                beat_count++;
            end
            // Predict with the registers in force before this edge
            if (s_tvalid && s_tready) begin
                expected_turns.push_back(predict_turns(s_tdata[READING_W-1:0],
                                                       s_tdata[2*READING_W-1:READING_W],
                                                       shadow_cfg));
            end
            // Mirror register writes
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_NEW_DEVICE_MODE: begin
                        shadow_cfg.new_device_mode = cfg_wr_data[0];
                    end
                    REG_HAND_SIDE: begin
                        shadow_cfg.hand_side = cfg_wr_data[0];
                    end
                    REG_FIRST_WHEEL_TEETH: begin
                        shadow_cfg.first_wheel_teeth = cfg_wr_data[TEETH_W-1:0];
                    end
                    REG_SECOND_WHEEL_TEETH: begin
                        shadow_cfg.second_wheel_teeth = cfg_wr_data[TEETH_W-1:0];
                    end
                    REG_INVERSE_COEFFICIENT: begin
                        shadow_cfg.inverse_coefficient = cfg_wr_data[COEF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        mismatches    <= bad_count;
        outstanding   <= expected_turns.size();
        turns_checked <= beat_count;
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives reading pairs and register settings into the turn counter, gives the verdict.
module tb_top;
    import detc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // s_tdata: [15:0] first_reading, [31:16] second_reading
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    // m_tdata: [8:0] turn_count, [15:9] zero
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;

    int                      mismatches;
    int                      outstanding;
    int                      turns_checked;
    int                      cycle_count;
    int                      pairs_sent;
    int                      settings_used;
    logic                    steady;

    dual_encoder_turn_count dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    turn_count_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .turns_checked (turns_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: a random stall with ready low before taking each beat, none in steady phases
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one reading pair after a random gap and hold it until taken
    task automatic send_pair(input logic [READING_W-1:0] p1, input logic [READING_W-1:0] p2);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {p2, p1};
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
    endtask

    // Drop valid and wait until every expected turn count has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
    endtask

    // Load a full register set while the block is idle
    task automatic set_config(input logic mode, input logic hand, input logic [7:0] n1,
                              input logic [7:0] n2, input logic [8:0] coef);
        drain_results();
        write_reg(REG_NEW_DEVICE_MODE, {8'd0, mode});
        write_reg(REG_HAND_SIDE, {8'd0, hand});
        write_reg(REG_FIRST_WHEEL_TEETH, {1'b0, n1});
        write_reg(REG_SECOND_WHEEL_TEETH, {1'b0, n2});
        write_reg(REG_INVERSE_COEFFICIENT, coef);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Readings lean on the range ends
    function automatic logic [READING_W-1:0] pick_reading();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Tooth counts: zero, the ends, small wheels and anything in between
    function automatic logic [7:0] pick_teeth();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3, 4, 5: return 8'($urandom_range(2, 8));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [8:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 9'h100;
            1: return 9'h0FF;
            2: return 9'h101;
            default: return 9'($urandom);
        endcase
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wr_data   = '0;
        pairs_sent    = 0;
        settings_used = 1;
        steady        = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h7FFF, 16'h8000);

        // Legacy wrap with the largest first wheel, a 254-tooth second wheel and coefficient -255
        set_config(1'b0, 1'b0, 8'd255, 8'd254, 9'h101);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h0001, 16'hFFFF);

        // New mode, right side: a zero remainder must give zero, not -N2
        set_config(1'b1, 1'b0, 8'd17, 8'd13, 9'd5);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'd12345, 16'hF752);
        send_pair(16'h8000, 16'h7FFF);

        // New mode, left side negates the second reading
        set_config(1'b1, 1'b1, 8'd3, 8'd255, 9'h0FF);
        send_pair(16'd100, 16'd200);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h0000);

        // Zero second tooth count gives zero in both modes
        set_config(1'b1, 1'b0, 8'd9, 8'd0, 9'd7);
        send_pair(16'd1234, 16'd5678);
        set_config(1'b0, 1'b1, 8'd9, 8'd0, 9'h1F0);
        send_pair(16'hFFFF, 16'hFFFF);

        // Zero first tooth count with the coefficient at its most negative value
        set_config(1'b0, 1'b0, 8'd0, 8'd7, 9'h100);
        send_pair(16'd5000, 16'hEC78);
        send_pair(16'h7FFF, 16'hFFFF);

        // Random phases: all mode and side pairs first, some with back-to-back beats
        for (int ph = 0; ph < 10; ph++) begin
            steady = (ph % 4 == 3);
            set_config(ph[0], (ph < 4) ? ph[1] : 1'($urandom_range(0, 1)),
                       pick_teeth(), pick_teeth(), pick_coef());
            repeat (55) send_pair(pick_reading(), pick_reading());
        end

        drain_results();
        repeat (40) @(negedge aclk);
        $display("%0d reading pairs over %0d register settings, %0d turn counts checked,",
                 pairs_sent, settings_used, turns_checked);
        $display("covering legacy and new modes, both sides, zero and full-size wheels");
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
